>>> sv/lambert_diffuse_shader_assert.svh
// ---------------------------------------------------------------------------
// Lambert shader assertion macros
// Concurrent checks on clk, quiet while arst_n is low; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef LAMBERT_DIFFUSE_SHADER_ASSERT_SVH
`define LAMBERT_DIFFUSE_SHADER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LDS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lambert shader check failed");

// next-cycle implication
`define LDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lambert shader check failed");

`else

`define LDS_ASSERT_IMPLY(lbl, ante, cons)
`define LDS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/lds_pkg.sv
// ---------------------------------------------------------------------------
// Lambert shader package
// Shared types, register indexes and fixed datapath widths.
// ---------------------------------------------------------------------------
package lds_pkg;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [16:0] dir_t;

	// light kinds
	localparam logic [1:0] KIND_DIR   = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_KIND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEC_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEC_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VEC_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd6;

	// geometry datapath
	localparam int SQ_W       = 33;  // one squared component
	localparam int ND_W       = 33;  // one normal*direction product
	localparam int SUMSQ_W    = 34;  // |d|^2
	localparam int DOT_W      = 34;  // positive dot product
	localparam int SQRT_PAD   = 28;  // radicand is |d|^2 << 28
	localparam int SQV_W      = SUMSQ_W + SQRT_PAD;
	localparam int SQ_STEPS   = SQV_W / 2;
	localparam int ROOT_W     = SQ_STEPS;
	localparam int REM_W      = ROOT_W + 2;
	localparam int COS_FRAC   = 14;
	localparam int NUM_W      = DOT_W + COS_FRAC;
	localparam int DV_STEPS   = 16;
	localparam int COS_W      = 15;
	localparam logic [COS_W-1:0] COS_ONE = 15'd16384;

	// shading datapath
	localparam int SH_W       = 9;
	localparam logic [SH_W-1:0] SHADOW_ONE = 9'd256;
	localparam int PROD1_W    = COS_W + SH_W;
	localparam int RND_SHIFT  = COS_FRAC + 8;

endpackage

>>> sv/lds_if.sv
// ---------------------------------------------------------------------------
// Lambert shader channels
// Surface point channel in, shaded color channel out; valid/ready transfer.
// ---------------------------------------------------------------------------
interface lds_surf_if #(parameter int COLOR_BITS = 8);
	import lds_pkg::*;

	logic                  valid;
	logic                  ready;
	coord_t                point_x;
	coord_t                point_y;
	coord_t                point_z;
	logic signed [15:0]    normal_x;
	logic signed [15:0]    normal_y;
	logic signed [15:0]    normal_z;
	logic [SH_W-1:0]       shadow_level;
	logic                  has_material;
	logic [COLOR_BITS-1:0] material_red;
	logic [COLOR_BITS-1:0] material_green;
	logic [COLOR_BITS-1:0] material_blue;

	modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
		shadow_level, has_material, material_red, material_green, material_blue,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
		shadow_level, has_material, material_red, material_green, material_blue,
		output ready);
endinterface

interface lds_color_if #(parameter int COLOR_BITS = 8);
	logic                  valid;
	logic                  ready;
	logic [COLOR_BITS-1:0] out_red;
	logic [COLOR_BITS-1:0] out_green;
	logic [COLOR_BITS-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> sv/lambert_diffuse_shader.sv
// ---------------------------------------------------------------------------
// Lambert diffuse shader
// Per surface point: diffuse color for one configured light, fully pipelined.
// ---------------------------------------------------------------------------
// channel  | dir | payload
// surf     | in  | point, normal, shadow level, material color
// shade    | out | out_red, out_green, out_blue
// cfg      | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// One item per cycle unless the output stalls. Three geometry stages, the
// 31-step square root, the 16-step cosine divide, four shading stages and the
// divide by the color maximum follow in that order. A stalled output parks one
// result in a skid register; the pipeline then freezes and surf.ready drops.
// Reset clears valids, light kind and vector, and sets light colors to maximum.
// ---------------------------------------------------------------------------
`include "lambert_diffuse_shader_assert.svh"

module lambert_diffuse_shader #(
	parameter int COLOR_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lds_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [lds_pkg::CFG_DATA_W-1:0]    cfg_data,
	lds_surf_if.sink                          surf,
	lds_color_if.source                       shade
);
	import lds_pkg::*;

	localparam int CB     = COLOR_BITS;
	localparam logic [CB-1:0] CMAX = '1;
	localparam int P2W    = PROD1_W + CB;
	localparam int P3W    = PROD1_W + 2 * CB;
	localparam int P3X    = P3W + 1;
	localparam int TW     = 2 * CB + 1;
	localparam int TX     = TW + 1;
	localparam int ST_SQ  = 3;
	localparam int ST_DV  = ST_SQ + SQ_STEPS;
	localparam int ST_M1  = ST_DV + DV_STEPS;
	localparam int ST_CD  = ST_M1 + 4;
	localparam int NST    = ST_CD + 1;
	localparam int LAST   = NST - 1;

	typedef struct packed {
		logic            kill;
		logic [SH_W-1:0] sh;
		logic [CB-1:0]   mr;
		logic [CB-1:0]   mg;
		logic [CB-1:0]   mb;
	} side_t;

	typedef logic [2:0][CB-1:0] rgb_t;

	// light registers
	logic [1:0]    kind_q;
	coord_t        vec_x_q, vec_y_q, vec_z_q;
	logic [CB-1:0] red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_DIR;
			vec_x_q <= '0;
			vec_y_q <= '0;
			vec_z_q <= '0;
			red_q   <= CMAX;
			green_q <= CMAX;
			blue_q  <= CMAX;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KIND:  kind_q  <= cfg_data[1:0];
				REG_VEC_X: vec_x_q <= coord_t'(cfg_data);
				REG_VEC_Y: vec_y_q <= coord_t'(cfg_data);
				REG_VEC_Z: vec_z_q <= coord_t'(cfg_data);
				REG_RED:   red_q   <= cfg_data[CB-1:0];
				REG_GREEN: green_q <= cfg_data[CB-1:0];
				REG_BLUE:  blue_q  <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	// global advance: pipeline moves while the skid register is free
	logic          en;
	logic [LAST:0] vld_s;
	logic          skid_v_q;

	assign en         = !skid_v_q;
	assign surf.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:0], surf.valid};
		end
	end

	// stage 1: direction to light, kill flags, shadow saturation
	dir_t  dx_c, dy_c, dz_c;
	dir_t  d_s1 [3];
	coord_t n_s1 [3];
	side_t side_s1;

	always_comb begin
		if (kind_q == KIND_DIR) begin
			dx_c = -dir_t'(vec_x_q);
			dy_c = -dir_t'(vec_y_q);
			dz_c = -dir_t'(vec_z_q);
		end else begin
			dx_c = dir_t'(vec_x_q) - dir_t'(surf.point_x);
			dy_c = dir_t'(vec_y_q) - dir_t'(surf.point_y);
			dz_c = dir_t'(vec_z_q) - dir_t'(surf.point_z);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= dx_c;
			d_s1[1] <= dy_c;
			d_s1[2] <= dz_c;
			n_s1[0] <= surf.normal_x;
			n_s1[1] <= surf.normal_y;
			n_s1[2] <= surf.normal_z;
			side_s1.kill <= !surf.has_material ||
				(kind_q != KIND_DIR && kind_q != KIND_POINT);
			side_s1.sh <= (surf.shadow_level > SHADOW_ONE) ? SHADOW_ONE : surf.shadow_level;
			side_s1.mr <= surf.material_red;
			side_s1.mg <= surf.material_green;
			side_s1.mb <= surf.material_blue;
		end
	end

	// stage 2: squares and normal products
	logic [SQ_W-1:0]        sq_s2 [3];
	logic signed [ND_W-1:0] nd_s2 [3];
	side_t                  side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SQ_W'(34'(d_s1[i] * d_s1[i]));
				nd_s2[i] <= ND_W'(n_s1[i] * d_s1[i]);
			end
			side_s2 <= side_s1;
		end
	end

	// stage 3: sums, zero-length and back-facing kill
	logic [SUMSQ_W-1:0]  ssum_c;
	logic signed [34:0]  dsum_c;
	side_t               side_s3_c;
	logic [SUMSQ_W-1:0]  s_s3;
	logic [DOT_W-1:0]    dot_s3;
	side_t               side_s3;

	assign ssum_c = SUMSQ_W'(sq_s2[0]) + SUMSQ_W'(sq_s2[1]) + SUMSQ_W'(sq_s2[2]);
	assign dsum_c = 35'(nd_s2[0]) + 35'(nd_s2[1]) + 35'(nd_s2[2]);

	always_comb begin
		side_s3_c      = side_s2;
		side_s3_c.kill = side_s2.kill || (ssum_c == '0) || dsum_c[34] || (dsum_c == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3    <= ssum_c;
			dot_s3  <= dsum_c[DOT_W-1:0];
			side_s3 <= side_s3_c;
		end
	end

	// square root of |d|^2 << 28, one root bit per stage
	logic [REM_W-1:0]   sq_rem_s  [SQ_STEPS];
	logic [ROOT_W-1:0]  sq_root_s [SQ_STEPS];
	logic [SUMSQ_W-1:0] sq_v_s    [SQ_STEPS];
	logic [DOT_W-1:0]   sq_dot_s  [SQ_STEPS];
	side_t              sq_side_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [REM_W-1:0]   rem_in;
		logic [ROOT_W-1:0]  root_in;
		logic [SUMSQ_W-1:0] s_in;
		logic [DOT_W-1:0]   dot_in;
		side_t              side_in;
		logic [SQV_W-1:0]   rad;
		logic [REM_W+1:0]   cur, trial, diff;
		logic               ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign s_in    = s_s3;
			assign dot_in  = dot_s3;
			assign side_in = side_s3;
		end else begin : g_next
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign s_in    = sq_v_s[k-1];
			assign dot_in  = sq_dot_s[k-1];
			assign side_in = sq_side_s[k-1];
		end

		assign rad   = {s_in, {SQRT_PAD{1'b0}}};
		assign cur   = {rem_in, rad[SQV_W-1-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
				sq_root_s[k] <= {root_in[ROOT_W-2:0], ge};
				sq_v_s[k]    <= s_in;
				sq_dot_s[k]  <= dot_in;
				sq_side_s[k] <= side_in;
			end
		end
	end

	// cosine = (dot << 14) / root, one quotient bit per stage
	logic [NUM_W-1:0]    dv_rem_s  [DV_STEPS];
	logic [DV_STEPS-1:0] dv_q_s    [DV_STEPS];
	logic [ROOT_W-1:0]   dv_r_s    [DV_STEPS];
	side_t               dv_side_s [DV_STEPS];

	for (genvar i = 0; i < DV_STEPS; i++) begin : g_div
		logic [NUM_W-1:0]    rem_in, sub;
		logic [DV_STEPS-1:0] q_in;
		logic [ROOT_W-1:0]   r_in;
		side_t               side_in;
		logic                ge;

		if (i == 0) begin : g_first
			assign rem_in  = {sq_dot_s[SQ_STEPS-1], {COS_FRAC{1'b0}}};
			assign q_in    = '0;
			assign r_in    = sq_root_s[SQ_STEPS-1];
			assign side_in = sq_side_s[SQ_STEPS-1];
		end else begin : g_next
			assign rem_in  = dv_rem_s[i-1];
			assign q_in    = dv_q_s[i-1];
			assign r_in    = dv_r_s[i-1];
			assign side_in = dv_side_s[i-1];
		end

		assign sub = NUM_W'(r_in) << (DV_STEPS - 1 - i);
		assign ge  = rem_in >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[i]  <= ge ? rem_in - sub : rem_in;
				dv_q_s[i]    <= {q_in[DV_STEPS-2:0], ge};
				dv_r_s[i]    <= r_in;
				dv_side_s[i] <= side_in;
			end
		end
	end

	// M1: clamp cosine, scale by shadow
	logic [DV_STEPS-1:0] q_fin;
	logic [COS_W-1:0]    cos_c;
	logic [PROD1_W-1:0]  p1_s;
	side_t               side_m1;

	assign q_fin = dv_q_s[DV_STEPS-1];
	assign cos_c = (q_fin > DV_STEPS'(COS_ONE)) ? COS_ONE : q_fin[COS_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s    <= PROD1_W'(cos_c) * PROD1_W'(dv_side_s[DV_STEPS-1].sh);
			side_m1 <= dv_side_s[DV_STEPS-1];
		end
	end

	// M2: times light color; M3: times material color; M4: round and drop 2^22
	rgb_t           lc, mc;
	logic [P2W-1:0] p2_s [3];
	logic [P3W-1:0] p3_s [3];
	logic [TW-1:0]  t_s  [3];
	logic [P3X-1:0] rsum [3];
	side_t          side_m2, side_m3;
	logic           kill_m4;

	assign lc[0] = red_q;
	assign lc[1] = green_q;
	assign lc[2] = blue_q;
	assign mc[0] = side_m2.mr;
	assign mc[1] = side_m2.mg;
	assign mc[2] = side_m2.mb;

	for (genvar c = 0; c < 3; c++) begin : g_rnd
		assign rsum[c] = P3X'(p3_s[c]) + (P3X'(CMAX) << (RND_SHIFT - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				p2_s[c] <= P2W'(p1_s) * P2W'(lc[c]);
				p3_s[c] <= P3W'(p2_s[c]) * P3W'(mc[c]);
				t_s[c]  <= rsum[c][RND_SHIFT +: TW];
			end
			side_m2 <= side_m1;
			side_m3 <= side_m2;
			kill_m4 <= side_m3.kill;
		end
	end

	// divide by the color maximum 2^CB - 1: (t + 1 + (t >> CB)) >> CB,
	// exact while t / (2^CB - 1) stays at or below the color maximum
	logic [TX-1:0] cd_sum [3];
	logic [CB-1:0] cq_s   [3];
	logic          ckill_s;

	for (genvar c = 0; c < 3; c++) begin : g_cdiv
		assign cd_sum[c] = TX'(t_s[c]) + TX'(t_s[c] >> CB) + TX'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				cq_s[c] <= cd_sum[c][CB +: CB];
			end
			ckill_s <= kill_m4;
		end
	end

	// final color with black for killed items
	rgb_t pipe_rgb;

	for (genvar c = 0; c < 3; c++) begin : g_res
		assign pipe_rgb[c] = ckill_s ? '0 : cq_s[c];
	end

	// output register plus skid register
	logic pipe_take, out_free, out_v_q;
	rgb_t out_q, skid_q;

	assign pipe_take = en && vld_s[LAST];
	assign out_free  = !out_v_q || shade.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || pipe_take;
			skid_v_q <= 1'b0;
		end else if (pipe_take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : pipe_rgb;
		end else if (pipe_take) begin
			skid_q <= pipe_rgb;
		end
	end

	assign shade.valid     = out_v_q;
	assign shade.out_red   = out_q[0];
	assign shade.out_green = out_q[1];
	assign shade.out_blue  = out_q[2];

	// checks
	`LDS_ASSERT_NEXT(a_accept_loads, surf.valid && surf.ready, vld_s[0])
	`LDS_ASSERT_IMPLY(a_skid_behind_out, skid_v_q, out_v_q)
	`LDS_ASSERT_IMPLY(a_root_nonzero, vld_s[ST_DV-1] && !sq_side_s[SQ_STEPS-1].kill, sq_root_s[SQ_STEPS-1] != '0)
	`LDS_ASSERT_IMPLY(a_cos_shadow_bound, vld_s[ST_M1], p1_s <= PROD1_W'(COS_ONE) * PROD1_W'(SHADOW_ONE))

endmodule

>>> tb/lambert_diffuse_shader_tb.sv
// ---------------------------------------------------------------------------
// Lambert diffuse shader testbench
// A queue-fed driver sends surface points and a clocked monitor checks each
// shaded color against an in-bench predictor. Both sides stall at random.
// The run goes through several light settings: directed corner items first,
// then random items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lambert_diffuse_shader_tb;
	import lds_pkg::*;

	localparam int  COLOR_BITS   = 8;
	localparam int  DRAIN_CYCLES = 80;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam logic [1:0] KIND_OTHER_A = 2'd2;
	localparam logic [1:0] KIND_OTHER_B = 2'd3;
	localparam longint unsigned SHADE_DEN = 64'd16384 * 64'd256 * 64'd255;

	typedef struct {
		logic signed [15:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [8:0]         shadow;
		logic               has_mat;
		logic [7:0]         mr, mg, mb;
	} surf_item_t;

	typedef struct {
		logic [7:0] r, g, b;
	} color_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	lds_surf_if  #(.COLOR_BITS(COLOR_BITS)) surf_ch ();
	lds_color_if #(.COLOR_BITS(COLOR_BITS)) shade_ch ();

	lambert_diffuse_shader #(.COLOR_BITS(COLOR_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.surf(surf_ch), .shade(shade_ch)
	);

	// light registers as the bench believes them
	logic [1:0]         lt_kind = KIND_DIR;
	logic signed [15:0] lt_x = '0, lt_y = '0, lt_z = '0;
	logic [7:0]         lt_r = 8'd255, lt_g = 8'd255, lt_b = 8'd255;

	surf_item_t pending_points[$];
	color_t     expected_colors[$];
	bit  hold_points = 1'b0;
	bit  calm = 1'b0;
	int  cycles = 0;
	int  errors = 0;
	int  points_sent = 0;
	int  colors_checked = 0;
	int  lit_colors = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bitwise integer square root
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] scale_channel(logic [7:0] lc, longint unsigned cosv,
			longint unsigned sh, logic [7:0] mc);
		longint unsigned prod;
		prod = longint'(lc) * cosv * sh * longint'(mc);
		return 8'((prod + SHADE_DEN / 2) / SHADE_DEN);
	endfunction

	// expected diffuse color for one surface point under the current light
	function automatic color_t predict_color(surf_item_t it);
		longint dx, dy, dz, dot;
		longint unsigned sumsq, root, cosv, sh;
		color_t res;
		res = '{8'd0, 8'd0, 8'd0};
		if (!it.has_mat)
			return res;
		case (lt_kind)
			KIND_DIR: begin
				dx = -longint'(lt_x);
				dy = -longint'(lt_y);
				dz = -longint'(lt_z);
			end
			KIND_POINT: begin
				dx = longint'(lt_x) - longint'(it.px);
				dy = longint'(lt_y) - longint'(it.py);
				dz = longint'(lt_z) - longint'(it.pz);
			end
			default: return res;
		endcase
		sumsq = dx * dx + dy * dy + dz * dz;
		if (sumsq == 0)
			return res;
		dot = longint'(it.nx) * dx + longint'(it.ny) * dy + longint'(it.nz) * dz;
		if (dot <= 0)
			return res;
		root = int_sqrt(sumsq << 28);
		cosv = (longint'(dot) << 14) / root;
		if (cosv > 16384)
			cosv = 16384;
		sh = (it.shadow > SHADOW_ONE) ? 256 : it.shadow;
		res.r = scale_channel(lt_r, cosv, sh, it.mr);
		res.g = scale_channel(lt_g, cosv, sh, it.mg);
		res.b = scale_channel(lt_b, cosv, sh, it.mb);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// driver: present the next queued point, idling at random
	always @(posedge clk) begin
		if (arst_n && (!surf_ch.valid || surf_ch.ready)) begin
			if (pending_points.size() > 0 && !hold_points &&
					(calm || $urandom_range(0, 99) >= 36)) begin
				surf_item_t it;
				it = pending_points.pop_front();
				surf_ch.valid          <= 1'b1;
				surf_ch.point_x        <= it.px;
				surf_ch.point_y        <= it.py;
				surf_ch.point_z        <= it.pz;
				surf_ch.normal_x       <= it.nx;
				surf_ch.normal_y       <= it.ny;
				surf_ch.normal_z       <= it.nz;
				surf_ch.shadow_level   <= it.shadow;
				surf_ch.has_material   <= it.has_mat;
				surf_ch.material_red   <= it.mr;
				surf_ch.material_green <= it.mg;
				surf_ch.material_blue  <= it.mb;
			end else begin
				surf_ch.valid <= 1'b0;
			end
		end
	end

	// sink stalls
	always @(posedge clk) begin
		if (arst_n)
			shade_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
	end

	// monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (surf_ch.valid && surf_ch.ready) begin
				surf_item_t it;
				color_t c;
				it.px = surf_ch.point_x;  it.py = surf_ch.point_y;  it.pz = surf_ch.point_z;
				it.nx = surf_ch.normal_x; it.ny = surf_ch.normal_y; it.nz = surf_ch.normal_z;
				it.shadow  = surf_ch.shadow_level;
				it.has_mat = surf_ch.has_material;
				it.mr = surf_ch.material_red;
				it.mg = surf_ch.material_green;
				it.mb = surf_ch.material_blue;
				c = predict_color(it);
				expected_colors.push_back(c);
				points_sent++;
			end
			if (shade_ch.valid && shade_ch.ready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected color transfer", 1, 0);
				end else begin
					color_t want;
					want = expected_colors.pop_front();
					if (shade_ch.out_red !== want.r)
						report_mismatch("out_red", shade_ch.out_red, want.r);
					if (shade_ch.out_green !== want.g)
						report_mismatch("out_green", shade_ch.out_green, want.g);
					if (shade_ch.out_blue !== want.b)
						report_mismatch("out_blue", shade_ch.out_blue, want.b);
					if (want.r != 0 || want.g != 0 || want.b != 0)
						lit_colors++;
				end
				colors_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		calm <= (cycles >= 3000 && cycles < 4500);
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic set_light(logic [1:0] kind, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		write_reg(REG_KIND, 16'(kind));
		write_reg(REG_VEC_X, x);
		write_reg(REG_VEC_Y, y);
		write_reg(REG_VEC_Z, z);
		write_reg(REG_RED, 16'(r));
		write_reg(REG_GREEN, 16'(g));
		write_reg(REG_BLUE, 16'(b));
		lt_kind = kind; lt_x = x; lt_y = y; lt_z = z;
		lt_r = r; lt_g = g; lt_b = b;
	endtask

	// wait until every point went out and every color came back
	task automatic drain();
		while (pending_points.size() > 0 || surf_ch.valid || expected_colors.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic surf_item_t make_point(int px, int py, int pz, int nx, int ny, int nz,
			int sh, bit mat, int mr, int mg, int mb);
		surf_item_t it;
		it.px = 16'(px); it.py = 16'(py); it.pz = 16'(pz);
		it.nx = 16'(nx); it.ny = 16'(ny); it.nz = 16'(nz);
		it.shadow = 9'(sh); it.has_mat = mat;
		it.mr = 8'(mr); it.mg = 8'(mg); it.mb = 8'(mb);
		return it;
	endfunction

	function automatic int rand_s16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int rand_normal();
		case ($urandom_range(0, 7))
			0: return 16384;
			1: return -16384;
			default: return int'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	function automatic int rand_color();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic surf_item_t random_point(bit near);
		surf_item_t it;
		int sh;
		sh = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
		it = make_point(rand_s16(), rand_s16(), rand_s16(), rand_normal(), rand_normal(),
			rand_normal(), sh, $urandom_range(0, 9) != 0, rand_color(), rand_color(),
			rand_color());
		// keep point lights close so the cosine varies over its range
		if (near) begin
			it.px = 16'(int'(lt_x) + int'($urandom_range(0, 2047)) - 1024);
			it.py = 16'(int'(lt_y) + int'($urandom_range(0, 2047)) - 1024);
			it.pz = 16'(int'(lt_z) + int'($urandom_range(0, 2047)) - 1024);
		end
		return it;
	endfunction

	initial begin
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		surf_ch.valid = 1'b0;
		surf_ch.point_x = '0; surf_ch.point_y = '0; surf_ch.point_z = '0;
		surf_ch.normal_x = '0; surf_ch.normal_y = '0; surf_ch.normal_z = '0;
		surf_ch.shadow_level = '0; surf_ch.has_material = 1'b0;
		surf_ch.material_red = '0; surf_ch.material_green = '0; surf_ch.material_blue = '0;
		shade_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset light: zero-length direction gives black
		pending_points.push_back(make_point(0, 0, 0, 0, 0, 16384, 256, 1, 255, 255, 255));
		pending_points.push_back(make_point(100, -5, 7, 16384, 0, 0, 256, 1, 200, 1, 9));
		drain();

		// directional light straight down the z axis
		set_light(KIND_DIR, 16'sd0, 16'sd0, -16'sd256, 8'd255, 8'd255, 8'd255);
		pending_points.push_back(make_point(0, 0, 0, 0, 0, 16384, 256, 1, 255, 255, 255));
		pending_points.push_back(make_point(0, 0, 0, 0, 0, 16384, 0, 1, 255, 255, 255));
		pending_points.push_back(make_point(0, 0, 0, 0, 0, 16384, 511, 1, 255, 128, 0));
		pending_points.push_back(make_point(0, 0, 0, 0, 0, 16384, 256, 0, 255, 255, 255));
		pending_points.push_back(make_point(0, 0, 0, 0, 0, -16384, 256, 1, 255, 255, 255));
		pending_points.push_back(make_point(0, 0, 0, 16384, 0, 0, 256, 1, 255, 255, 255));
		pending_points.push_back(make_point(0, 0, 0, 16384, 16384, 16384, 256, 1, 77, 1, 254));
		pending_points.push_back(make_point(0, 0, 0, 11585, 0, 11585, 128, 1, 255, 255, 255));
		drain();

		// point light at one corner, points at the opposite corner and elsewhere
		set_light(KIND_POINT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd0, 8'd128, 8'd255);
		pending_points.push_back(make_point(-32768, -32768, -32768, 9459, 9459, 9459, 256, 1,
			255, 255, 255));
		pending_points.push_back(make_point(32767, 32767, 32767, 0, 0, 16384, 256, 1,
			255, 255, 255));
		pending_points.push_back(make_point(32767, 32767, 0, -16384, -16384, 16384, 200, 1,
			255, 255, 255));
		pending_points.push_back(make_point(-32768, 32767, -1, 16384, 0, 16384, 256, 1,
			255, 255, 255));
		drain();

		// other light kinds give black
		set_light(KIND_OTHER_A, -16'sd256, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255);
		pending_points.push_back(make_point(0, 0, 0, 16384, 0, 0, 256, 1, 255, 255, 255));
		drain();
		set_light(KIND_OTHER_B, 16'sh8000, 16'sh8000, 16'sh8000, 8'd255, 8'd255, 8'd255);
		pending_points.push_back(make_point(0, 0, 0, 16384, 0, 0, 256, 1, 255, 255, 255));
		drain();

		// random phases, each under a fresh light
		for (int phase = 0; phase < 8; phase++) begin
			logic [1:0] kind;
			bit near;
			kind = (phase == 5) ? KIND_OTHER_A : ((phase % 2) ? KIND_POINT : KIND_DIR);
			case (phase)
				0: set_light(kind, 16'sh8000, 16'sh8000, 16'sh8000, 8'd255, 8'd255, 8'd255);
				2: set_light(kind, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd0, 8'd0, 8'd0);
				default: set_light(kind, 16'(rand_s16()), 16'(rand_s16()), 16'(rand_s16()),
					8'(rand_color()), 8'(rand_color()), 8'(rand_color()));
			endcase
			near = (kind == KIND_POINT) && (phase != 7);
			for (int i = 0; i < 215; i++) begin
				pending_points.push_back(random_point(near));
				if (phase == 3 && i == 100) begin
					// let the pipeline empty before sending the rest
					while (pending_points.size() > 0) @(posedge clk);
					hold_points = 1'b1;
					while (surf_ch.valid || expected_colors.size() > 0) @(posedge clk);
					hold_points = 1'b0;
				end
			end
			drain();
		end

		$display("Shaded %0d surface points, %0d colors checked, %0d of them not black.",
			points_sent, colors_checked, lit_colors);
		$display("Covered directional, point and other light kinds with corner settings.");
		if (errors == 0 && expected_colors.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
